// ----- src/modbus_response_frame_checker_core_macros.svh -----
// Assertion macros shared by the frame checker RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef MODBUS_RESPONSE_FRAME_CHECKER_CORE_MACROS_SVH
`define MODBUS_RESPONSE_FRAME_CHECKER_CORE_MACROS_SVH

// Condition c must hold in the same cycle as a.
`define MRFC_ASSERT_SAME(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (c)) \
        else $error(msg);

// Condition c must hold in the cycle after a.
`define MRFC_ASSERT_NEXT(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (c)) \
        else $error(msg);

`endif

// ----- src/mrfc_pkg.sv -----
// Package for the Modbus response frame checker: beat types, frame record,
// CRC-16 byte update and protocol constants. Depends on nothing.
`default_nettype none

package mrfc_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  EXC_MASK  = 8'hF0;
    localparam logic [7:0]  EXC_CODE  = 8'h80;
    localparam logic [7:0]  FC_MASK   = 8'h0F;
    localparam logic [7:0]  FC_WRITE  = 8'h06;
    localparam logic [7:0]  FC_READ   = 8'h03;
    localparam logic [2:0]  CRC_BYTES = 3'd6;
    localparam logic [2:0]  LAST_POS  = 3'd7;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_CRC_ERROR = 3'd1;
    localparam logic [2:0] ST_EXCEPTION = 3'd2;
    localparam logic [2:0] ST_BAD_FC    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;

    localparam logic KIND_MOTOR  = 1'b0;
    localparam logic KIND_SENSOR = 1'b1;

    localparam logic [1:0] CFG_MOTOR_ID    = 2'd0;
    localparam logic [1:0] CFG_SENSOR_ID   = 2'd1;
    localparam logic [1:0] CFG_SENSOR_ADDR = 2'd2;

    localparam logic [7:0]  MOTOR_ID_RESET    = 8'd1;
    localparam logic [7:0]  SENSOR_ID_RESET   = 8'd2;
    localparam logic [15:0] SENSOR_ADDR_RESET = 16'd1;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        node_kind;
        logic [7:0]  function_code;
        logic [15:0] reg_address;
        logic [15:0] reply_value;
    } out_beat_t;

    typedef struct packed {
        logic [7:0]  node_id;
        logic [7:0]  function_code;
        logic [15:0] reg_address;
        logic [15:0] reply_value;
        logic        crc_ok;
    } frame_rec_t;

    typedef struct packed {
        logic [7:0]  motor_node_id;
        logic [7:0]  sensor_node_id;
        logic [15:0] sensor_value_addr;
    } cfg_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/mrfc_front.sv -----
// Front end: counts frame bytes, keeps the CRC and the first seven bytes,
// and emits one frame record per complete frame. Depends on mrfc_pkg.
`default_nettype none

module mrfc_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              beat_en,
    input  wire mrfc_pkg::in_beat_t beat,
    output logic                   rec_push,
    output mrfc_pkg::frame_rec_t   rec
);

    logic [2:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  store_reg [7];
    logic [2:0]  pos_eff;
    logic [15:0] crc_eff;
    logic        last_byte;

    always_comb begin
        pos_eff   = beat.frame_start ? 3'd0 : pos_reg;
        crc_eff   = beat.frame_start ? mrfc_pkg::CRC_INIT : crc_reg;
        last_byte = (pos_eff == mrfc_pkg::LAST_POS);
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        if (beat_en) begin
            if (last_byte) begin
                pos_next = 3'd0;
                crc_next = mrfc_pkg::CRC_INIT;
            end else begin
                pos_next = pos_eff + 3'd1;
                crc_next = (pos_eff < mrfc_pkg::CRC_BYTES) ?
                           mrfc_pkg::crc_byte(crc_eff, beat.rx_byte) : crc_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 3'd0;
            crc_reg <= mrfc_pkg::CRC_INIT;
        end else begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_en && !last_byte) begin
            store_reg[pos_eff] <= beat.rx_byte;
        end
    end

    assign rec_push          = beat_en && last_byte;
    assign rec.node_id       = store_reg[0];
    assign rec.function_code = store_reg[1];
    assign rec.reg_address   = {store_reg[2], store_reg[3]};
    assign rec.reply_value   = {store_reg[4], store_reg[5]};
    assign rec.crc_ok        = ({store_reg[6], beat.rx_byte} == crc_reg);

endmodule

`default_nettype wire

// ----- src/mrfc_queue.sv -----
// Small FIFO of frame records between the front end and the classifier.
// Depends on mrfc_pkg and the assertion macro header.
`default_nettype none
`include "modbus_response_frame_checker_core_macros.svh"

module mrfc_queue #(
    parameter int DEPTH = mrfc_pkg::QUEUE_DEPTH
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire mrfc_pkg::frame_rec_t push_rec,
    output logic                      full,
    output logic                      head_valid,
    output mrfc_pkg::frame_rec_t      head_rec,
    input  wire logic                 pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mrfc_pkg::frame_rec_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = mem_reg[rd_ptr_reg];

    `MRFC_ASSERT_SAME(a_no_overflow, aclk, aresetn, push, !full || pop, "queue overflow")
    `MRFC_ASSERT_SAME(a_no_underflow, aclk, aresetn, pop, head_valid, "queue underflow")
    `MRFC_ASSERT_SAME(a_count_range, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH), "bad count")
    `MRFC_ASSERT_NEXT(a_push_grows, aclk, aresetn, push && !pop, head_valid, "push lost")

endmodule

`default_nettype wire

// ----- src/mrfc_back.sv -----
// Back end: classifies queued frame records and holds the result beat in an
// output register until it is taken. Depends on mrfc_pkg.
`default_nettype none

module mrfc_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire mrfc_pkg::cfg_t       cfg,
    input  wire logic                 head_valid,
    input  wire mrfc_pkg::frame_rec_t head_rec,
    output logic                      pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output mrfc_pkg::out_beat_t       m_data
);

    logic                valid_reg, valid_next;
    mrfc_pkg::out_beat_t data_reg;
    mrfc_pkg::out_beat_t result;
    logic                is_exc;
    logic [7:0]          fc_low;

    always_comb begin
        is_exc = ((head_rec.function_code & mrfc_pkg::EXC_MASK) == mrfc_pkg::EXC_CODE);
        fc_low = head_rec.function_code & mrfc_pkg::FC_MASK;
        result.function_code = head_rec.function_code;
        result.reg_address   = head_rec.reg_address;
        result.reply_value   = head_rec.reply_value;
        result.node_kind     = mrfc_pkg::KIND_MOTOR;
        if (!head_rec.crc_ok) begin
            result.status = mrfc_pkg::ST_CRC_ERROR;
        end else if (head_rec.node_id == cfg.motor_node_id) begin
            if (is_exc) begin
                result.status = mrfc_pkg::ST_EXCEPTION;
            end else if (fc_low == mrfc_pkg::FC_WRITE || fc_low == mrfc_pkg::FC_READ) begin
                result.status = mrfc_pkg::ST_ACCEPTED;
            end else begin
                result.status = mrfc_pkg::ST_BAD_FC;
            end
        end else if (head_rec.node_id == cfg.sensor_node_id) begin
            result.node_kind = mrfc_pkg::KIND_SENSOR;
            if (is_exc) begin
                result.status = mrfc_pkg::ST_EXCEPTION;
            end else if (fc_low == mrfc_pkg::FC_READ &&
                         head_rec.reg_address == cfg.sensor_value_addr) begin
                result.status = mrfc_pkg::ST_ACCEPTED;
            end else begin
                result.status = mrfc_pkg::ST_BAD_FC;
            end
        end else begin
            result.status = mrfc_pkg::ST_UNKNOWN;
        end
    end

    assign pop = head_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

// ----- src/modbus_response_frame_checker_core.sv -----
// Modbus RTU response frame checker, top level: configuration registers,
// front end, record queue and classifier. Depends on mrfc_pkg and submodules.
//
// Usage: frame bytes enter on the s_ channel, one byte per beat, with
// frame_start marking the first byte of a frame. Eight bytes make a frame;
// the CRC-16 over the first six is compared with the last two. After the
// eighth byte one result beat leaves on the m_ channel with a status, the
// node kind and the raw function code, address and value fields.
// Throughput: one byte per cycle while s_ready is high; the CRC byte update
// is a single unrolled step in the front end. The edge that accepts the
// eighth byte writes the queue; a later edge, once the output register is
// empty or being taken, loads the classifier's output register and m_valid.
// The queue holds QUEUE_DEPTH frame records; when it fills because the
// receiver holds m_ready low, s_ready drops until a record moves on.
// Reset (aresetn low at a clock edge) clears the byte count, the CRC, the
// queue and the output valid, and loads the register defaults: motor node 1,
// sensor node 2, sensor address 1. Register writes take effect at once and
// are meant for an idle block.
`default_nettype none

module modbus_response_frame_checker_core #(
    parameter int QUEUE_DEPTH = mrfc_pkg::QUEUE_DEPTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mrfc_pkg::in_beat_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mrfc_pkg::out_beat_t      m_data,
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_wdata
);

    mrfc_pkg::cfg_t       cfg_reg, cfg_next;
    mrfc_pkg::frame_rec_t rec;
    mrfc_pkg::frame_rec_t head_rec;
    logic                 rec_push;
    logic                 q_full;
    logic                 head_valid;
    logic                 pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                mrfc_pkg::CFG_MOTOR_ID:    cfg_next.motor_node_id     = cfg_wdata[7:0];
                mrfc_pkg::CFG_SENSOR_ID:   cfg_next.sensor_node_id    = cfg_wdata[7:0];
                mrfc_pkg::CFG_SENSOR_ADDR: cfg_next.sensor_value_addr = cfg_wdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.motor_node_id     <= mrfc_pkg::MOTOR_ID_RESET;
            cfg_reg.sensor_node_id    <= mrfc_pkg::SENSOR_ID_RESET;
            cfg_reg.sensor_value_addr <= mrfc_pkg::SENSOR_ADDR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready = !q_full;

    mrfc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .beat_en  (s_valid && s_ready),
        .beat     (s_data),
        .rec_push (rec_push),
        .rec      (rec)
    );

    mrfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (rec_push),
        .push_rec   (rec),
        .full       (q_full),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop)
    );

    mrfc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire
